FILE: hdl/first_fit_heap_allocator_defines.svh
// Assertion macros for the first-fit heap allocator.
// Used by the top level only; needs nothing else.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FFHA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/ffha_pkg.sv
// Shared constants for the first-fit heap allocator.
// No dependencies.
`default_nettype none
package ffha_pkg;
  localparam int unsigned HeapWordsDefault = 4096;
  localparam logic [2:0] OpAlloc  = 3'd0;
  localparam logic [2:0] OpAllocZ = 3'd1;
  localparam logic [2:0] OpFree   = 3'd2;
  localparam logic [2:0] OpRealloc = 3'd3;
  localparam logic [2:0] OpRead   = 3'd4;
  localparam logic [2:0] OpWrite  = 3'd5;
endpackage
`default_nettype wire

FILE: hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with its heap memory and sequencer.
// Depends on ffha_pkg and first_fit_heap_allocator_defines.svh.
// A request runs as a chain of states: the sequencer walks block headers (SWalkSz,
// SWalkW, SWalkFr, SWalkChk), then zeroes word by word in SZero, copies word by word
// through SCpRd and SCpWr, and on free merges each following free block through SFrSz,
// SFrNxF, SFrNxS, SFrChk and SFrWr. A word read passes SWRdW and SDone, a word write
// goes straight to SDone. After reset SInit0 and SInit1 write the first header before
// the first request is taken. The heap is one single-port memory with registered reads.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_WORDS = ffha_pkg::HeapWordsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] request_bytes_i,
  input  wire logic [13:0] pointer_offset_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [13:0]      result_offset_o,
  output logic [31:0]      read_data_o,
  output logic             status_o
);
  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam logic [34:0] HeapBytes = 35'(HEAP_WORDS) * 35'd4;

  localparam logic [4:0] SInit0 = 5'd0, SInit1 = 5'd1, SIdle = 5'd2,
    SWRd = 5'd3, SWRdW = 5'd4, SWalkSz = 5'd5, SWalkFr = 5'd6, SWalkChk = 5'd7,
    SSplit0 = 5'd8, SSplit1 = 5'd9, SSplit2 = 5'd10, SMark = 5'd11,
    SZero = 5'd12, SCpRd = 5'd13, SCpWr = 5'd14, SFrMark = 5'd15,
    SFrSz = 5'd16, SFrNxF = 5'd17, SFrNxS = 5'd18, SFrChk = 5'd19,
    SFrWr = 5'd20, SDone = 5'd21, SOldRd = 5'd22, SOldW = 5'd23, SWalkW = 5'd24;

  logic [31:0] mem_q [HEAP_WORDS];
  logic [31:0] rdata_q;
  logic        we;
  logic [34:0] waddr_w, raddr_w;
  logic [31:0] wdata_w;
  logic        re;

  logic [4:0]  st_q, st_d;
  logic [2:0]  op_q, op_d;
  logic [31:0] req_q, req_d;
  logic [13:0] ptr_q, ptr_d;
  logic [34:0] n_q, n_d, b_q, b_d, cnt_q, cnt_d;
  logic [31:0] sz_q, sz_d, tmp_q, tmp_d;
  logic        ov_q, ov_d;
  logic [13:0] res_q, res_d;
  logic [31:0] rd_q, rd_d;
  logic        stat_q, stat_d;
  logic [34:0] nreq, np_w, nb_w, sum_w, csz_w;
  logic        in_ok;

  always_ff @(posedge clk_i) begin
    if (we && waddr_w < 35'(HEAP_WORDS)) begin
      mem_q[waddr_w[AW-1:0]] <= wdata_w;
    end
    if (re) begin
      rdata_q <= (raddr_w < 35'(HEAP_WORDS)) ? mem_q[raddr_w[AW-1:0]] : 32'd0;
    end
  end

  assign in_stall_o = (st_q != SIdle) || ov_q;
  assign in_ok = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign result_offset_o = res_q;
  assign read_data_o = rd_q;
  assign status_o = stat_q;
  assign nreq = ((35'(req_q) + 35'd7) & ~35'd7);
  assign np_w = b_q + 35'd8;
  assign nb_w = b_q + 35'd8 + 35'(sz_q);
  assign sum_w = 35'(sz_q) + 35'd8 + 35'(rdata_q);
  assign csz_w = (35'(tmp_q) < 35'(req_q)) ? 35'(tmp_q) : 35'(req_q);

  always_comb begin
    st_d = st_q; op_d = op_q; req_d = req_q; ptr_d = ptr_q;
    n_d = n_q; b_d = b_q; cnt_d = cnt_q; sz_d = sz_q; tmp_d = tmp_q;
    ov_d = ov_q && out_stall_i;
    res_d = res_q; rd_d = rd_q; stat_d = stat_q;
    we = 1'b0; waddr_w = '0; wdata_w = '0; re = 1'b0; raddr_w = '0;
    case (st_q)
      SInit0: begin
        we = 1'b1; waddr_w = 35'd0; wdata_w = 32'(HeapBytes - 35'd8); st_d = SInit1;
      end
      SInit1: begin
        we = 1'b1; waddr_w = 35'd1; wdata_w = 32'd1; st_d = SIdle;
      end
      SIdle: begin
        if (in_ok) begin
          op_d = opcode_i; req_d = request_bytes_i; ptr_d = pointer_offset_i;
          res_d = '0; rd_d = '0; stat_d = 1'b0;
          case (opcode_i)
            ffha_pkg::OpAlloc, ffha_pkg::OpAllocZ: st_d = SWRd;
            ffha_pkg::OpRealloc: st_d = SOldRd;
            ffha_pkg::OpFree: begin
              b_d = 35'(pointer_offset_i) - 35'd8;
              st_d = (pointer_offset_i >= 14'd8 && 35'(pointer_offset_i) < HeapBytes)
                ? SFrMark : SDone;
            end
            ffha_pkg::OpRead: begin
              re = 1'b1; raddr_w = 35'(pointer_offset_i); st_d = SWRdW;
            end
            ffha_pkg::OpWrite: begin
              we = 35'(pointer_offset_i) < 35'(HEAP_WORDS);
              waddr_w = 35'(pointer_offset_i); wdata_w = write_data_i; st_d = SDone;
            end
            default: st_d = SDone;
          endcase
        end
      end
      SWRdW: begin
        rd_d = rdata_q; st_d = SDone;
      end
      SOldRd: begin
        if (ptr_q >= 14'd8 && 35'(ptr_q) < HeapBytes) begin
          re = 1'b1; raddr_w = (35'(ptr_q) - 35'd8) >> 2; st_d = SOldW;
        end else begin
          ptr_d = '0; st_d = SWRd;
        end
      end
      SOldW: begin
        tmp_d = rdata_q; st_d = SWRd;
      end
      SWRd: begin
        n_d = (nreq == 35'd0) ? 35'd8 : nreq; b_d = '0;
        if (nreq > HeapBytes) begin
          st_d = SDone; stat_d = 1'b1;
        end else begin
          st_d = SWalkSz;
        end
      end
      SWalkSz: begin
        if (b_q + 35'd8 <= HeapBytes) begin
          re = 1'b1; raddr_w = b_q >> 2; st_d = SWalkW;
        end else begin
          stat_d = 1'b1; st_d = SDone;
        end
      end
      SWalkW: begin
        sz_d = rdata_q;
        re = 1'b1; raddr_w = (b_q >> 2) + 35'd1; st_d = SWalkFr;
      end
      SWalkFr: begin
        st_d = SWalkChk;
      end
      SWalkChk: begin
        if (rdata_q != 32'd0 && 35'(sz_q) >= n_q) begin
          st_d = (35'(sz_q) >= n_q + 35'd16) ? SSplit0 : SMark;
        end else begin
          b_d = nb_w; st_d = SWalkSz;
        end
      end
      SSplit0: begin
        we = 1'b1; waddr_w = (b_q + 35'd8 + n_q) >> 2;
        wdata_w = 32'(35'(sz_q) - n_q - 35'd8); st_d = SSplit1;
      end
      SSplit1: begin
        we = 1'b1; waddr_w = ((b_q + 35'd8 + n_q) >> 2) + 35'd1; wdata_w = 32'd1;
        st_d = SSplit2;
      end
      SSplit2: begin
        we = 1'b1; waddr_w = b_q >> 2; wdata_w = n_q[31:0]; sz_d = n_q[31:0];
        st_d = SMark;
      end
      SMark: begin
        we = 1'b1; waddr_w = (b_q >> 2) + 35'd1; wdata_w = 32'd0;
        res_d = np_w[13:0]; cnt_d = '0;
        if (op_q == ffha_pkg::OpAllocZ) begin
          st_d = SZero;
        end else if (op_q == ffha_pkg::OpRealloc && ptr_q != '0) begin
          st_d = SCpRd;
        end else begin
          st_d = SDone;
        end
      end
      SZero: begin
        if (cnt_q < 35'(sz_q) && np_w + cnt_q < HeapBytes) begin
          we = 1'b1; waddr_w = (np_w + cnt_q) >> 2; cnt_d = cnt_q + 35'd4;
        end else begin
          st_d = SDone;
        end
      end
      SCpRd: begin
        if (cnt_q < ((csz_w + 35'd3) >> 2) && (35'(ptr_q) >> 2) + cnt_q < 35'(HEAP_WORDS)
            && (np_w >> 2) + cnt_q < 35'(HEAP_WORDS)) begin
          re = 1'b1; raddr_w = (35'(ptr_q) >> 2) + cnt_q; st_d = SCpWr;
        end else begin
          b_d = 35'(ptr_q) - 35'd8; st_d = SFrMark;
        end
      end
      SCpWr: begin
        we = 1'b1; waddr_w = (np_w >> 2) + cnt_q; wdata_w = rdata_q;
        cnt_d = cnt_q + 35'd1; st_d = SCpRd;
      end
      SFrMark: begin
        we = 1'b1; waddr_w = (b_q >> 2) + 35'd1; wdata_w = 32'd1; st_d = SFrSz;
      end
      SFrSz: begin
        re = 1'b1; raddr_w = b_q >> 2; st_d = SFrNxF;
      end
      SFrNxF: begin
        sz_d = rdata_q;
        if (b_q + 35'd8 + 35'(rdata_q) >= HeapBytes ||
            ((b_q + 35'd8 + 35'(rdata_q)) >> 2) + 35'd1 >= 35'(HEAP_WORDS)) begin
          st_d = SDone;
        end else begin
          re = 1'b1; raddr_w = ((b_q + 35'd8 + 35'(rdata_q)) >> 2) + 35'd1;
          st_d = SFrNxS;
        end
      end
      SFrNxS: begin
        if (rdata_q == 32'd0) begin
          st_d = SDone;
        end else begin
          re = 1'b1; raddr_w = nb_w >> 2; st_d = SFrChk;
        end
      end
      SFrChk: begin
        if (sum_w > 35'h0FFFFFFFF) begin
          st_d = SDone;
        end else begin
          tmp_d = sum_w[31:0]; st_d = SFrWr;
        end
      end
      SFrWr: begin
        we = 1'b1; waddr_w = b_q >> 2; wdata_w = tmp_q; st_d = SFrSz;
      end
      SDone: begin
        ov_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; req_q <= req_d; ptr_q <= ptr_d;
    n_q <= n_d; b_q <= b_d; cnt_q <= cnt_d; sz_q <= sz_d; tmp_q <= tmp_d;
    res_q <= res_d; rd_q <= rd_d; stat_q <= stat_d;
  end

  `FFHA_ASSERT_IMPL(a_busy_stalls, st_q != SIdle, in_stall_o)
  `FFHA_ASSERT_IMPL(a_fail_no_ptr, out_valid_o && status_o, result_offset_o == 14'd0)
  `FFHA_ASSERT_NEXT(a_done_out, st_q == SDone, out_valid_o)
  `FFHA_ASSERT_IMPL(a_no_rw, we && re, 1'b0)
endmodule
`default_nettype wire

FILE: bench/ffha_checker.sv
// Checker for the first-fit heap allocator: predicts every result from its own heap image.
// Watches both channels of the block and depends on ffha_pkg for the request codes.
`timescale 1ns / 1ps
module ffha_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] request_bytes_i,
  input  logic [13:0] pointer_offset_i,
  input  logic [31:0] write_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [13:0] result_offset_i,
  input  logic [31:0] read_data_i,
  input  logic        status_i,
  output int          fail_count_o
);
  localparam int unsigned NumWords = 4096;
  localparam longint unsigned NumBytes = 64'd16384;

  typedef struct {
    logic [13:0] offset;
    logic [31:0] rdata;
    logic        status;
  } heap_result_t;

  logic [31:0]  heap_mem [NumWords];
  heap_result_t result_q [$];
  int unsigned  live_ptrs [$];
  int           accepted_count;

  function automatic logic [31:0] heap_rd(longint unsigned idx);
    return (idx < NumWords) ? heap_mem[idx] : 32'd0;
  endfunction

  function automatic void heap_wr(longint unsigned idx, logic [31:0] v);
    if (idx < NumWords) heap_mem[idx] = v;
  endfunction

  function automatic void drop_live(int unsigned p);
    int idx;
    idx = -1;
    foreach (live_ptrs[k]) if (live_ptrs[k] == p) idx = k;
    if (idx >= 0) live_ptrs.delete(idx);
  endfunction

  function automatic longint unsigned model_alloc(logic [31:0] req, bit zero);
    longint unsigned n, b, sz, fr, nb, len, i, a;
    n = (longint'(req) + 64'd7) & ~64'd7;
    b = 0;
    if (n == 0) n = 8;
    if (n > NumBytes) return 0;
    while (b + 8 <= NumBytes) begin
      sz = heap_rd(b >> 2);
      fr = heap_rd((b >> 2) + 1);
      if (fr != 0 && sz >= n) begin
        if (sz >= n + 16) begin
          nb = b + 8 + n;
          heap_wr(nb >> 2, 32'(sz - n - 8));
          heap_wr((nb >> 2) + 1, 32'd1);
          heap_wr(b >> 2, 32'(n));
        end
        heap_wr((b >> 2) + 1, 32'd0);
        if (zero) begin
          len = heap_rd(b >> 2);
          for (i = 0; i < len; i += 4) begin
            a = b + 8 + i;
            if (a >= NumBytes) break;
            heap_wr(a >> 2, 32'd0);
          end
        end
        return b + 8;
      end
      b += 8 + sz;
    end
    return 0;
  endfunction

  function automatic bit ptr_ok(longint unsigned p);
    return p >= 8 && p < NumBytes;
  endfunction

  function automatic void model_free(longint unsigned p);
    longint unsigned b, sz, nb, sum;
    if (!ptr_ok(p)) return;
    b = p - 8;
    heap_wr((b >> 2) + 1, 32'd1);
    forever begin
      sz = heap_rd(b >> 2);
      nb = b + 8 + sz;
      if (nb >= NumBytes || (nb >> 2) + 1 >= NumWords) break;
      if (heap_rd((nb >> 2) + 1) == 0) break;
      sum = sz + 8 + heap_rd(nb >> 2);
      if (sum > 64'hFFFF_FFFF) break;
      heap_wr(b >> 2, 32'(sum));
    end
  endfunction

  function automatic longint unsigned model_realloc(longint unsigned p, logic [31:0] req);
    longint unsigned oldsz, np, c, words, i, s, d;
    if (!ptr_ok(p)) return model_alloc(req, 1'b0);
    oldsz = heap_rd((p - 8) >> 2);
    np = model_alloc(req, 1'b0);
    if (np == 0) return 0;
    c = (oldsz < req) ? oldsz : longint'(req);
    words = (c + 3) >> 2;
    for (i = 0; i < words; i++) begin
      s = (p >> 2) + i;
      d = (np >> 2) + i;
      if (s >= NumWords || d >= NumWords) break;
      heap_mem[d] = heap_mem[s];
    end
    model_free(p);
    return np;
  endfunction

  function automatic heap_result_t predict_request(logic [2:0] op, logic [31:0] req,
                                                   logic [13:0] ptr, logic [31:0] wd);
    heap_result_t r;
    longint unsigned res;
    r = '{offset: '0, rdata: '0, status: 1'b0};
    res = 0;
    case (op)
      ffha_pkg::OpAlloc, ffha_pkg::OpAllocZ: begin
        res = model_alloc(req, op == ffha_pkg::OpAllocZ);
        r.status = (res == 0);
        if (res != 0) live_ptrs.push_back(int'(res));
      end
      ffha_pkg::OpFree: begin
        model_free(ptr);
        if (ptr_ok(ptr)) drop_live(ptr);
      end
      ffha_pkg::OpRealloc: begin
        res = model_realloc(ptr, req);
        r.status = (res == 0);
        if (res != 0) begin
          if (ptr_ok(ptr)) drop_live(ptr);
          live_ptrs.push_back(int'(res));
        end
      end
      ffha_pkg::OpRead: r.rdata = heap_rd(ptr);
      ffha_pkg::OpWrite: heap_wr(ptr, wd);
      default: ;
    endcase
    r.offset = res[13:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      foreach (heap_mem[k]) heap_mem[k] = '0;
      heap_mem[0] = 32'(NumBytes - 8);
      heap_mem[1] = 32'd1;
      result_q.delete();
      live_ptrs.delete();
      accepted_count = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no request waiting", {18'd0, result_offset_i}, 0);
        end else begin
          want = result_q.pop_front();
          if (result_offset_i !== want.offset)
            report_mismatch("result_offset", {18'd0, result_offset_i}, {18'd0, want.offset});
          if (read_data_i !== want.rdata) report_mismatch("read_data", read_data_i, want.rdata);
          if (status_i !== want.status)
            report_mismatch("status", {31'd0, status_i}, {31'd0, want.status});
        end
      end
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(predict_request(opcode_i, request_bytes_i, pointer_offset_i,
                                           write_data_i));
        accepted_count++;
      end
    end
  end
endmodule

FILE: bench/tb.sv
// Testbench top for the first-fit heap allocator: drives requests and gives the verdict.
// Depends on ffha_pkg, first_fit_heap_allocator and ffha_checker.
`timescale 1ns / 1ps
module tb;
  localparam longint CycleLimit = 200_000_000;
  localparam int RandomItems = 1700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = '0;
  logic [31:0] request_bytes = '0;
  logic [13:0] pointer_offset = '0;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] result_offset;
  logic [31:0] read_data;
  logic        status;
  int          fail_count;
  int          issued = 0;
  int          item_idx = 0;
  longint      cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  first_fit_heap_allocator dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .request_bytes_i(request_bytes),
    .pointer_offset_i(pointer_offset), .write_data_i(write_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_offset_o(result_offset), .read_data_o(read_data), .status_o(status)
  );

  ffha_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .request_bytes_i(request_bytes),
    .pointer_offset_i(pointer_offset), .write_data_i(write_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .result_offset_i(result_offset), .read_data_i(read_data), .status_i(status),
    .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycles == 20000) begin
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk_i);
      end
      out_stall <= (cycles > 40000 && cycles < 70000) ? 1'b0 : ($urandom_range(0, 99) < 20);
    end
  end

  task automatic send(logic [2:0] op, logic [31:0] req, logic [13:0] ptr, logic [31:0] wd);
    opcode <= op;
    request_bytes <= req;
    pointer_offset <= ptr;
    write_data <= wd;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    issued++;
    item_idx++;
    wait (chk.accepted_count == issued);
    if ((item_idx < 600 || item_idx > 900) && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 64);
    if (r < 95) return $urandom_range(65, 512);
    if (r < 98) return $urandom_range(513, 20000);
    return (r == 98) ? $urandom() : 32'hFFFF_FFF0 | $urandom_range(0, 15);
  endfunction

  function automatic logic [13:0] pick_live();
    return 14'(chk.live_ptrs[$urandom_range(0, chk.live_ptrs.size() - 1)]);
  endfunction

  task automatic random_request();
    int unsigned r, n, sz;
    logic [13:0] p;
    n = chk.live_ptrs.size();
    r = $urandom_range(0, 99);
    if (n > 40 && r < 50) r = 30;
    if (r < 22) send(ffha_pkg::OpAlloc, rand_request(), 14'($urandom()), $urandom());
    else if (r < 30) send(ffha_pkg::OpAllocZ, rand_request(), 14'($urandom()), $urandom());
    else if (r < 50) begin
      p = (n == 0 || $urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 7)) : pick_live();
      send(ffha_pkg::OpFree, $urandom(), p, $urandom());
    end else if (r < 65) begin
      p = (n == 0 || $urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 7)) : pick_live();
      send(ffha_pkg::OpRealloc, rand_request(), p, $urandom());
    end else if (r < 80) send(ffha_pkg::OpRead, $urandom(), 14'($urandom()), $urandom());
    else if (r < 95) begin
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        p = pick_live();
        sz = chk.heap_mem[(p - 8) >> 2];
        p = 14'((p >> 2) + $urandom_range(0, sz / 4 - 1));
      end else p = 14'($urandom_range(4096, 16383));
      send(ffha_pkg::OpWrite, $urandom(), p, $urandom());
    end else send(3'($urandom_range(6, 7)), $urandom(), 14'($urandom()), $urandom());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Zero the whole heap once so that every later read sees written words.
    send(ffha_pkg::OpAllocZ, 32'd16376, 14'd0, 32'd0);
    send(ffha_pkg::OpFree, 32'd0, 14'd8, 32'd0);
    send(ffha_pkg::OpAlloc, 32'd0, 14'd0, 32'd0);
    send(ffha_pkg::OpAlloc, 32'd1, 14'd0, 32'd0);
    send(ffha_pkg::OpAlloc, 32'hFFFF_FFFF, 14'd0, 32'd0);
    send(ffha_pkg::OpAlloc, 32'd16377, 14'd0, 32'd0);
    send(ffha_pkg::OpAllocZ, 32'd16376, 14'd0, 32'd0);
    send(ffha_pkg::OpRead, 32'd0, 14'h3FFF, 32'd0);
    send(ffha_pkg::OpWrite, 32'd0, 14'h3FFF, 32'hFFFF_FFFF);
    send(ffha_pkg::OpRead, 32'd0, 14'd0, 32'd0);
    send(3'd6, 32'hFFFF_FFFF, 14'h3FFF, 32'hFFFF_FFFF);
    send(3'd7, 32'd0, 14'd0, 32'd0);
    send(ffha_pkg::OpFree, 32'd0, 14'd0, 32'd0);
    send(ffha_pkg::OpFree, 32'd0, 14'd7, 32'd0);
    send(ffha_pkg::OpRealloc, 32'd20, 14'd0, 32'd0);
    send(ffha_pkg::OpWrite, 32'd0, 14'(chk.live_ptrs[$] >> 2), 32'hA5A5_5A5A);
    send(ffha_pkg::OpRealloc, 32'hFFFF_FFF8, 14'(chk.live_ptrs[$]), 32'd0);
    send(ffha_pkg::OpRealloc, 32'd100, 14'(chk.live_ptrs[$]), 32'd0);
    send(ffha_pkg::OpRead, 32'd0, 14'(chk.live_ptrs[$] >> 2), 32'd0);
    send(ffha_pkg::OpRealloc, 32'd4, 14'(chk.live_ptrs[$]), 32'd0);
    send(ffha_pkg::OpAllocZ, 32'd40, 14'd0, 32'd0);
    send(ffha_pkg::OpFree, 32'd0, 14'(chk.live_ptrs[0]), 32'd0);
    send(ffha_pkg::OpFree, 32'd0, 14'(chk.live_ptrs[0]), 32'd0);
    repeat (RandomItems) random_request();
    in_valid <= 1'b0;
    wait (chk.result_q.size() == 0);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
